>>> hw/rtl/fplc_pkg.sv
package fplc_pkg;

  localparam int unsigned WINDOW_DEFAULT = 32;

  localparam int unsigned FRAME_W   = 20;
  localparam int unsigned STAGE_W   = 2;
  localparam int unsigned AVG_W     = 28;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned GOOD_W    = 7;
  localparam int unsigned BAD_W     = 2;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic [FRAME_W-1:0] DEFAULT_REFRESH_US = 20'd16667;
  localparam logic [GOOD_W-1:0]  MIN_PROMOTE        = 7'd2;
  localparam logic [GOOD_W-1:0]  MAX_PROMOTE        = 7'd64;
  localparam logic [GOOD_W-1:0]  GOOD_RUN_MAX       = 7'd127;
  localparam logic [BAD_W-1:0]   BAD_RUN_MAX        = 2'd3;
  localparam logic [BAD_W-1:0]   DEMOTE_RUN         = 2'd2;
  localparam logic [STAGE_W-1:0] TOP_STAGE          = 2'd3;
  localparam logic [STAGE_W-1:0] BEST_STAGE         = 2'd0;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX          = 32'hFFFF_FFFF;

  // input kinds carried on the slave tuser
  localparam logic MODE_FRAME     = 1'b0;
  localparam logic MODE_INTERRUPT = 1'b1;

  // register word index (paddr[2])
  localparam logic REG_REFRESH = 1'b0;

  typedef struct packed {
    logic                 stage_changed;
    logic [STAGE_W-1:0]   stage;
    logic [1:0]           frame_latency;
    logic                 vsync_on;
    logic [FRAME_W-1:0]   average_frame_us;
    logic [TOTAL_W-1:0]   total_late;
    logic [TOTAL_W-1:0]   stage_change_count;
  } fplc_result_t;

  function automatic logic [1:0] stage_latency(input logic [STAGE_W-1:0] s);
    return s[1] ? 2'd2 : 2'd1;
  endfunction

  function automatic logic stage_vsync(input logic [STAGE_W-1:0] s);
    return ~s[0];
  endfunction

endpackage

>>> hw/rtl/fplc_regs.sv
module fplc_regs
  import fplc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [FRAME_W-1:0] refresh_eff
);

  logic [FRAME_W-1:0] refresh_period_us;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_REFRESH);

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period_us <= DEFAULT_REFRESH_US;
    end else if (wr_en) begin
      refresh_period_us <= pwdata[FRAME_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_REFRESH) begin
      prdata = {{(APB_DW-FRAME_W){1'b0}}, refresh_period_us};
    end else begin
      prdata = '0;
    end
  end

  // a programmed zero falls back to the default period
  assign refresh_eff = (refresh_period_us != '0) ? refresh_period_us : DEFAULT_REFRESH_US;

endmodule

>>> hw/rtl/fplc_core.sv
module fplc_core
  import fplc_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic               mode,
  input  logic [FRAME_W-1:0] frame_time_us,
  input  logic [FRAME_W-1:0] refresh_eff,
  output fplc_result_t       result
);

  localparam int unsigned CNT_W     = $clog2(WINDOW + 1);
  localparam int unsigned SKIP_W    = $clog2(WINDOW / 2 + 1);
  localparam int unsigned AVG_SHIFT = $clog2(WINDOW + 1) - 1;

  localparam logic [CNT_W-1:0]  WINDOW_LEN = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0]  LATE_LIMIT = CNT_W'(WINDOW / 4);
  localparam logic [SKIP_W-1:0] SKIP_LOAD  = SKIP_W'(WINDOW / 2);

  logic [STAGE_W-1:0] current_stage, current_stage_next;
  logic [AVG_W-1:0]   average_fixed, average_fixed_next;
  logic [SKIP_W-1:0]  skip_left, skip_left_next;
  logic [CNT_W-1:0]   frames_in_window, frames_in_window_next;
  logic [CNT_W-1:0]   late_in_window, late_in_window_next;
  logic [GOOD_W-1:0]  good_run, good_run_next;
  logic [BAD_W-1:0]   bad_run, bad_run_next;
  logic [GOOD_W-1:0]  promote_need, promote_need_next;
  logic [TOTAL_W-1:0] late_total, late_total_next;
  logic [TOTAL_W-1:0] change_total, change_total_next;

  logic [AVG_W-1:0]   f8;
  logic [AVG_W-1:0]   avg_diff;
  logic [AVG_W-1:0]   avg_step;
  logic [AVG_W-1:0]   avg_upd;
  logic               is_late;
  logic [CNT_W-1:0]   frames_inc;
  logic [CNT_W-1:0]   late_inc;
  logic [GOOD_W-1:0]  good_inc;
  logic [BAD_W-1:0]   bad_inc;
  logic               changed;

  assign f8       = {frame_time_us, {FRAC_W{1'b0}}};
  assign avg_diff = (f8 >= average_fixed) ? (f8 - average_fixed) : (average_fixed - f8);
  assign avg_step = avg_diff >> AVG_SHIFT;
  assign avg_upd  = (f8 >= average_fixed) ? (average_fixed + avg_step)
                                          : (average_fixed - avg_step);

  // late when 2*f > 3*refresh
  assign is_late = {1'b0, frame_time_us, 1'b0} >
                   ({2'b00, refresh_eff} + {1'b0, refresh_eff, 1'b0});

  assign late_inc   = is_late ? late_in_window + 1'b1 : late_in_window;
  assign frames_inc = frames_in_window + 1'b1;
  assign good_inc   = (good_run < GOOD_RUN_MAX) ? good_run + 1'b1 : good_run;
  assign bad_inc    = (bad_run < BAD_RUN_MAX) ? bad_run + 1'b1 : bad_run;

  always_comb begin
    current_stage_next    = current_stage;
    average_fixed_next    = average_fixed;
    skip_left_next        = skip_left;
    frames_in_window_next = frames_in_window;
    late_in_window_next   = late_in_window;
    good_run_next         = good_run;
    bad_run_next          = bad_run;
    promote_need_next     = promote_need;
    late_total_next       = late_total;
    change_total_next     = change_total;
    changed               = 1'b0;

    if (mode == MODE_INTERRUPT) begin
      skip_left_next        = SKIP_LOAD;
      bad_run_next          = '0;
      frames_in_window_next = '0;
      late_in_window_next   = '0;
    end else if (frame_time_us != '0) begin
      average_fixed_next = avg_upd;
      if (skip_left != '0) begin
        skip_left_next = skip_left - 1'b1;
      end else begin
        if (is_late && late_total != TOTAL_MAX) begin
          late_total_next = late_total + 1'b1;
        end
        if (frames_inc < WINDOW_LEN) begin
          frames_in_window_next = frames_inc;
          late_in_window_next   = late_inc;
        end else begin
          frames_in_window_next = '0;
          late_in_window_next   = '0;
          if (late_inc > LATE_LIMIT) begin
            good_run_next = '0;
            bad_run_next  = bad_inc;
            if (bad_inc >= DEMOTE_RUN && current_stage < TOP_STAGE) begin
              if (promote_need < MAX_PROMOTE) begin
                promote_need_next = {promote_need[GOOD_W-2:0], 1'b0};
              end
              current_stage_next = current_stage + 1'b1;
              changed            = 1'b1;
            end
          end else if (late_inc != '0) begin
            good_run_next = '0;
          end else begin
            bad_run_next = '0;
            if (current_stage != BEST_STAGE) begin
              good_run_next = good_inc;
              if (good_inc >= promote_need) begin
                current_stage_next = current_stage - 1'b1;
                changed            = 1'b1;
              end
            end
          end
        end
      end
    end

    // a stage change restarts measurement around the new stage
    if (changed) begin
      if (change_total != TOTAL_MAX) begin
        change_total_next = change_total + 1'b1;
      end
      good_run_next         = '0;
      bad_run_next          = '0;
      skip_left_next        = SKIP_LOAD;
      average_fixed_next    = {refresh_eff, {FRAC_W{1'b0}}};
      frames_in_window_next = '0;
      late_in_window_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_stage    <= BEST_STAGE;
      average_fixed    <= {DEFAULT_REFRESH_US, {FRAC_W{1'b0}}};
      skip_left        <= SKIP_LOAD;
      frames_in_window <= '0;
      late_in_window   <= '0;
      good_run         <= '0;
      bad_run          <= '0;
      promote_need     <= MIN_PROMOTE;
      late_total       <= '0;
      change_total     <= '0;
    end else if (go) begin
      current_stage    <= current_stage_next;
      average_fixed    <= average_fixed_next;
      skip_left        <= skip_left_next;
      frames_in_window <= frames_in_window_next;
      late_in_window   <= late_in_window_next;
      good_run         <= good_run_next;
      bad_run          <= bad_run_next;
      promote_need     <= promote_need_next;
      late_total       <= late_total_next;
      change_total     <= change_total_next;
    end
  end

  always_comb begin
    result.stage_changed      = changed;
    result.stage              = current_stage_next;
    result.frame_latency      = stage_latency(current_stage_next);
    result.vsync_on           = stage_vsync(current_stage_next);
    result.average_frame_us   = average_fixed_next[AVG_W-1:FRAC_W];
    result.total_late         = late_total_next;
    result.stage_change_count = change_total_next;
  end

endmodule

>>> hw/rtl/frame_pacing_ladder_controller_unit.sv
// channel   direction  payload
// s_*       in         tuser: mode; tdata: frame_time_us (24 bits, padded)
// m_*       out        tdata: stage_changed .. stage_change_count (96 bits, padded)
// apb       in/out     refresh_period_us at byte address 0, pready tied high
//
// one item per cycle while m_tready keeps up: an input register feeds the state update,
// which loads the result register and sets m_tvalid when the item advances.
// rst (synchronous) restores refresh 16667 us, stage 0, promote threshold 2.
// a stalled m_tready holds the result and lets one more item wait in the
// input register; s_tready drops only when both are full.
module frame_pacing_ladder_controller_unit
  import fplc_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // [19:0] frame_time_us
  input  logic              s_tuser,   // [0] mode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [95:0]       m_tdata,   // [0] stage_changed, [2:1] stage,
                                       // [4:3] frame_latency, [5] vsync_on,
                                       // [25:6] average_frame_us, [57:26] total_late,
                                       // [89:58] stage_change_count
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic               in_valid;
  logic               in_mode;
  logic [FRAME_W-1:0] in_frame;
  logic               advance;
  logic [FRAME_W-1:0] refresh_eff;
  fplc_result_t       result;
  fplc_result_t       out_result;

  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode  <= s_tuser;
      in_frame <= s_tdata[FRAME_W-1:0];
    end
  end

  fplc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .refresh_eff (refresh_eff)
  );

  fplc_core #(
    .WINDOW (WINDOW)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .go            (advance),
    .mode          (in_mode),
    .frame_time_us (in_frame),
    .refresh_eff   (refresh_eff),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {6'b0,
                    out_result.stage_change_count,
                    out_result.total_late,
                    out_result.average_frame_us,
                    out_result.vsync_on,
                    out_result.frame_latency,
                    out_result.stage,
                    out_result.stage_changed};

endmodule

>>> tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fplc_pkg::*;

  localparam int unsigned WIN          = 32;
  localparam int unsigned AVG_SHIFT    = 5;
  localparam int unsigned SKIP_RELOAD  = WIN / 2;
  localparam int unsigned STALL_MAX    = 16;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS  = 195;
  localparam int unsigned PHASES       = 8;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  typedef struct packed {
    logic               mode;
    logic [FRAME_W-1:0] frame_us;
  } pacing_item_t;

  typedef enum int unsigned {
    TRAFFIC_CLEAN,
    TRAFFIC_BAD,
    TRAFFIC_MIXED,
    TRAFFIC_NOISE
  } traffic_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata  = '0;   // [19:0] frame_time_us
  logic              s_tuser  = 1'b0; // [0] mode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [95:0]       m_tdata;         // [0] stage_changed, [2:1] stage, [4:3] frame_latency,
                                      // [5] vsync_on, [25:6] average_frame_us,
                                      // [57:26] total_late, [89:58] stage_change_count
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [APB_AW-1:0] paddr    = '0;
  logic [APB_DW-1:0] pwdata   = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  frame_pacing_ladder_controller_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ladder state mirrored by the bench; skip and window counters are wider than the block's
  logic [FRAME_W-1:0] refresh_us;
  logic [STAGE_W-1:0] ladder_stage;
  logic [AVG_W-1:0]   avg_fixed;
  logic [9:0]         skip_left;
  logic [10:0]        win_fill;
  logic [10:0]        window_late;
  logic [GOOD_W-1:0]  good_run;
  logic [GOOD_W-1:0]  promote_need;
  logic [BAD_W-1:0]   bad_run;
  logic [TOTAL_W-1:0] late_total;
  logic [TOTAL_W-1:0] change_total;

  pacing_item_t item_q[$];
  fplc_result_t ladder_status_q[$];

  pacing_item_t tx_item;
  int unsigned  tx_wait      = 0;
  int unsigned  tx_mood_left = 0;
  bit           tx_calm      = 1'b0;
  int unsigned  rx_wait      = 0;
  int unsigned  rx_mood_left = 0;
  bit           rx_calm      = 1'b0;
  int unsigned  idle_cycles  = 0;
  int unsigned  fail_count   = 0;

  function automatic logic [FRAME_W-1:0] live_refresh();
    return (refresh_us == '0) ? DEFAULT_REFRESH_US : refresh_us;
  endfunction

  function automatic void clear_window();
    win_fill    = '0;
    window_late = '0;
  endfunction

  function automatic void move_stage(input logic [STAGE_W-1:0] next_stage);
    ladder_stage = next_stage;
    if (change_total != TOTAL_MAX) change_total++;
    good_run  = '0;
    bad_run   = '0;
    skip_left = 10'(SKIP_RELOAD);
    avg_fixed = {live_refresh(), 8'h00};
    clear_window();
  endfunction

  // returns 1 when the sample closes a window that moves the stage
  function automatic logic take_frame(input logic [FRAME_W-1:0] f);
    logic [AVG_W-1:0] f8;
    logic [10:0]      late_count;
    f8 = {f, 8'h00};
    if (f8 >= avg_fixed) avg_fixed = avg_fixed + ((f8 - avg_fixed) >> AVG_SHIFT);
    else avg_fixed = avg_fixed - ((avg_fixed - f8) >> AVG_SHIFT);

    if (skip_left != '0) begin
      skip_left--;
      return 1'b0;
    end

    if ({3'b000, f, 1'b0} > 24'(live_refresh()) * 24'd3) begin
      if (window_late < 11'h7FF) window_late++;
      if (late_total != TOTAL_MAX) late_total++;
    end
    if (win_fill < 11'h7FF) win_fill++;
    if (win_fill < 11'(WIN)) return 1'b0;

    late_count = window_late;
    clear_window();

    if (late_count > 11'(WIN / 4)) begin
      good_run = '0;
      if (bad_run < BAD_RUN_MAX) bad_run++;
      if (bad_run < DEMOTE_RUN || ladder_stage >= TOP_STAGE) return 1'b0;
      if (promote_need < MAX_PROMOTE) promote_need = promote_need << 1;
      move_stage(ladder_stage + 2'd1);
      return 1'b1;
    end
    if (late_count != '0) begin
      good_run = '0;
      return 1'b0;
    end
    bad_run = '0;
    if (ladder_stage == BEST_STAGE) return 1'b0;
    if (good_run < GOOD_RUN_MAX) good_run++;
    if (good_run < promote_need) return 1'b0;
    move_stage(ladder_stage - 2'd1);
    return 1'b1;
  endfunction

  function automatic void step_ladder(input pacing_item_t it);
    fplc_result_t r;
    logic         moved;
    moved = 1'b0;
    if (it.mode == MODE_INTERRUPT) begin
      skip_left = 10'(SKIP_RELOAD);
      bad_run   = '0;
      clear_window();
    end else if (it.frame_us != '0) begin
      moved = take_frame(it.frame_us);
    end
    r.stage_changed      = moved;
    r.stage              = ladder_stage;
    r.frame_latency      = ladder_stage[1] ? 2'd2 : 2'd1;
    r.vsync_on           = (ladder_stage == 2'd0) || (ladder_stage == 2'd2);
    r.average_frame_us   = avg_fixed[AVG_W-1:FRAC_W];
    r.total_late         = late_total;
    r.stage_change_count = change_total;
    ladder_status_q.push_back(r);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void queue_item(input logic mode, input logic [FRAME_W-1:0] f);
    pacing_item_t it;
    it.mode     = mode;
    it.frame_us = f;
    item_q.push_back(it);
  endfunction

  // frame time on either side of the late threshold for the current refresh
  function automatic logic [FRAME_W-1:0] draw_frame(input bit late);
    int unsigned thr;
    thr = int'(live_refresh()) * 3 / 2;
    if (thr >= FRAME_MAX) return FRAME_W'($urandom_range(1, FRAME_MAX));
    if (late) return FRAME_W'($urandom_range(thr + 1, FRAME_MAX));
    return FRAME_W'($urandom_range(1, thr));
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || s_tvalid || ladder_status_q.size() != 0);
  endtask

  task automatic write_refresh(input logic [FRAME_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_REFRESH, 2'b00};
    pwdata  <= {12'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    refresh_us = value;
  endtask

  always @(posedge clk) begin : driver
    pacing_item_t nxt;
    int unsigned  w;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      w = tx_wait;
      if (s_tvalid && s_tready) begin
        step_ladder(tx_item);
        w = tx_calm ? 0 : $urandom_range(0, STALL_MAX);
      end
      if (!s_tvalid || s_tready) begin
        if (w != 0) begin
          s_tvalid <= 1'b0;
          tx_wait  <= w - 1;
        end else if (item_q.size() != 0) begin
          nxt = item_q.pop_front();
          tx_item  <= nxt;
          s_tdata  <= {4'b0000, nxt.frame_us};
          s_tuser  <= nxt.mode;
          s_tvalid <= 1'b1;
          tx_wait  <= 0;
          // alternate stretches of back-to-back traffic with gappy traffic
          if (tx_mood_left == 0) begin
            tx_mood_left <= $urandom_range(16, 96);
            tx_calm      <= ($urandom_range(0, 2) == 0);
          end else begin
            tx_mood_left <= tx_mood_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
          tx_wait  <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    fplc_result_t want;
    int unsigned  w;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else begin
      w = rx_wait;
      if (m_tvalid && m_tready) begin
        if (ladder_status_q.size() == 0) begin
          $error("result transaction with no pending status");
          fail_count++;
        end else begin
          want = ladder_status_q.pop_front();
          compare_field("stage_changed", 32'(want.stage_changed), 32'(m_tdata[0]));
          compare_field("stage", 32'(want.stage), 32'(m_tdata[2:1]));
          compare_field("frame_latency", 32'(want.frame_latency), 32'(m_tdata[4:3]));
          compare_field("vsync_on", 32'(want.vsync_on), 32'(m_tdata[5]));
          compare_field("average_frame_us", 32'(want.average_frame_us), 32'(m_tdata[25:6]));
          compare_field("total_late", want.total_late, m_tdata[57:26]);
          compare_field("stage_change_count", want.stage_change_count, m_tdata[89:58]);
        end
        if (rx_mood_left == 0) begin
          rx_mood_left <= $urandom_range(16, 96);
          rx_calm      <= ($urandom_range(0, 2) == 0);
        end else begin
          rx_mood_left <= rx_mood_left - 1;
        end
        w = rx_calm ? 0 : $urandom_range(0, STALL_MAX);
      end
      if (w != 0) begin
        m_tready <= 1'b0;
        rx_wait  <= w - 1;
      end else begin
        m_tready <= 1'b1;
        rx_wait  <= 0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [FRAME_W-1:0] refresh_plan [PHASES];
    traffic_t           traffic;
    pacing_item_t       it;
    int unsigned        late_pct;
    int unsigned        seg_len;
    int unsigned        done;
    int unsigned        pick;
    int unsigned        n;
    int unsigned        p;

    refresh_us    = DEFAULT_REFRESH_US;
    ladder_stage  = BEST_STAGE;
    avg_fixed     = {DEFAULT_REFRESH_US, 8'h00};
    skip_left     = 10'(SKIP_RELOAD);
    clear_window();
    good_run      = '0;
    bad_run       = '0;
    promote_need  = MIN_PROMOTE;
    late_total    = '0;
    change_total  = '0;

    refresh_plan[0] = '0;                // falls back to the default period
    refresh_plan[1] = 20'd1;
    refresh_plan[2] = FRAME_MAX;         // nothing can be late
    refresh_plan[3] = FRAME_W'($urandom_range(2, FRAME_MAX - 1));
    refresh_plan[4] = 20'd8333;
    refresh_plan[5] = 20'd33333;
    refresh_plan[6] = 20'd4000;
    refresh_plan[7] = DEFAULT_REFRESH_US;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: interrupts, ignored sample, field extremes, late threshold edge
    queue_item(MODE_INTERRUPT, '0);
    queue_item(MODE_INTERRUPT, FRAME_MAX);
    queue_item(MODE_FRAME, '0);
    queue_item(MODE_FRAME, 20'd1);
    queue_item(MODE_FRAME, FRAME_MAX);
    queue_item(MODE_FRAME, 20'd25000);
    queue_item(MODE_FRAME, 20'd25001);
    queue_item(MODE_FRAME, 20'd16667);
    queue_item(MODE_FRAME, 20'h55555);
    queue_item(MODE_FRAME, 20'hAAAAA);
    // run out the skip period, the last one lands in the window as late
    for (n = 0; n < 10; n++) queue_item(MODE_FRAME, 20'd25001);
    queue_item(MODE_FRAME, 20'd25000);
    queue_item(MODE_FRAME, FRAME_MAX);
    queue_item(MODE_FRAME, 20'd1);
    queue_item(MODE_INTERRUPT, 20'd123);

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      write_refresh(refresh_plan[p]);
      done = 0;
      while (done < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) traffic = TRAFFIC_BAD;
        else if (pick < 7) traffic = TRAFFIC_CLEAN;
        else if (pick < 9) traffic = TRAFFIC_MIXED;
        else traffic = TRAFFIC_NOISE;
        case (traffic)
          TRAFFIC_BAD:   late_pct = $urandom_range(40, 95);
          TRAFFIC_MIXED: late_pct = $urandom_range(3, 15);
          default:       late_pct = 0;
        endcase
        seg_len = $urandom_range(24, 120);
        for (n = 0; n < seg_len && done < PHASE_ITEMS; n++) begin
          pick = $urandom_range(0, 199);
          if (traffic == TRAFFIC_NOISE) begin
            it.mode     = ($urandom_range(0, 7) == 0) ? MODE_INTERRUPT : MODE_FRAME;
            it.frame_us = FRAME_W'($urandom);
          end else if (pick == 0) begin
            it.mode     = MODE_INTERRUPT;
            it.frame_us = FRAME_W'($urandom);
          end else if (pick < 4) begin
            it.mode     = MODE_FRAME;
            it.frame_us = '0;
          end else begin
            it.mode     = MODE_FRAME;
            it.frame_us = draw_frame($urandom_range(0, 99) < late_pct);
          end
          item_q.push_back(it);
          if (it.mode == MODE_INTERRUPT || it.frame_us != '0) done++;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && ladder_status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/fplc_pkg.sv
hw/rtl/fplc_regs.sv
hw/rtl/fplc_core.sv
hw/rtl/frame_pacing_ladder_controller_unit.sv
tb/testbench.sv
